### hw/rtl/block_mean_and_std_dev_unit_assert.svh
// Assertion macros shared by the block mean and standard deviation unit.
`ifndef BLOCK_MEAN_AND_STD_DEV_UNIT_ASSERT_SVH
`define BLOCK_MEAN_AND_STD_DEV_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define BMSD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BMSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BMSD_ASSERT(lbl, clk, rst, prop, msg)
`define BMSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### hw/rtl/bmsd_pkg.sv
// Shared types and constants of the block mean and standard deviation unit.
package bmsd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GROUP_W  = 8;
  localparam int ROOT_W   = 16;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic rd_sq;
    logic acc_clr;
    logic mean_ld;
    logic sqrt_load;
    logic sqrt_step;
    logic emit;
  } bmsd_cmd_t;

endpackage

### hw/rtl/block_mean_and_std_dev_unit.sv
// Top level of the block mean and population standard deviation unit.
// A sample that does not complete a group is stored while busy stays low.
// The sample that completes a group holds busy high through two read passes over the N
// stored samples, each followed by a drain of the read pipeline, the 16-step square root and an
// emit state that registers the result; done pulses in the same cycle that busy falls.
// Synchronous reset clears the fill count, group counter and strobe; the sample memory is not cleared.
`include "block_mean_and_std_dev_unit_assert.svh"

module block_mean_and_std_dev_unit #(
  parameter int GROUP_SIZE = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bmsd_pkg::SAMPLE_W-1:0] sample,
  output logic                          done,
  output logic [bmsd_pkg::GROUP_W-1:0]  group_number,
  output logic [bmsd_pkg::SAMPLE_W-1:0] mean_value,
  output logic [bmsd_pkg::ROOT_W-1:0]   std_dev
);

  bmsd_pkg::bmsd_cmd_t           cmd;
  logic [$clog2(GROUP_SIZE)-1:0] addr;
  logic                          pipe_busy;

  bmsd_ctrl #(
    .GROUP_SIZE(GROUP_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .pipe_busy (pipe_busy),
    .busy      (busy),
    .cmd       (cmd),
    .addr      (addr)
  );

  bmsd_datapath #(
    .GROUP_SIZE(GROUP_SIZE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .addr         (addr),
    .sample       (sample),
    .pipe_busy    (pipe_busy),
    .done         (done),
    .group_number (group_number),
    .mean_value   (mean_value),
    .std_dev      (std_dev)
  );

  `BMSD_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "done strobe lasted more than one cycle")
  `BMSD_ASSERT(a_done_idle, clk, rst, !done || !busy, "result shown while still busy")
  `BMSD_ASSERT(a_busy_ends_done, clk, rst, !$fell(busy) || done, "busy ended without a result")
  `BMSD_ASSERT(a_load_drained, clk, rst, !(cmd.mean_ld || cmd.sqrt_load) || !pipe_busy, "load before the read pipeline drained")

endmodule

### hw/rtl/bmsd_ctrl.sv
// Controller state machine that sequences sample storage and group computation.
module bmsd_ctrl #(
  parameter int GROUP_SIZE = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          pipe_busy,
  output logic                          busy,
  output bmsd_pkg::bmsd_cmd_t           cmd,
  output logic [$clog2(GROUP_SIZE)-1:0] addr
);

  localparam int AW    = $clog2(GROUP_SIZE);
  localparam int CNT_W = $clog2(GROUP_SIZE + bmsd_pkg::ROOT_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_WAIT,
    ST_SQ_RD,
    ST_SQ_WAIT,
    ST_SQRT,
    ST_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [AW-1:0]    fill;
  logic             fill_last;
  logic             rd_last;
  logic             sqrt_last;

  assign fill_last = (fill == AW'(GROUP_SIZE - 1));
  assign rd_last   = (cnt == CNT_W'(GROUP_SIZE - 1));
  assign sqrt_last = (cnt == CNT_W'(bmsd_pkg::ROOT_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      fill  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (fill_last) begin
              fill  <= '0;
              cnt   <= '0;
              state <= ST_SUM_RD;
            end else begin
              fill <= fill + AW'(1);
            end
          end
        end
        ST_SUM_RD: begin
          cnt <= rd_last ? '0 : cnt + CNT_W'(1);
          if (rd_last) state <= ST_SUM_WAIT;
        end
        ST_SUM_WAIT: begin
          if (!pipe_busy) state <= ST_SQ_RD;
        end
        ST_SQ_RD: begin
          cnt <= rd_last ? '0 : cnt + CNT_W'(1);
          if (rd_last) state <= ST_SQ_WAIT;
        end
        ST_SQ_WAIT: begin
          if (!pipe_busy) begin
            cnt   <= '0;
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          cnt <= sqrt_last ? '0 : cnt + CNT_W'(1);
          if (sqrt_last) state <= ST_EMIT;
        end
        ST_EMIT: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.wr_en   = start;
        cmd.acc_clr = start && fill_last;
      end
      ST_SUM_RD: begin
        cmd.rd_en = 1'b1;
      end
      ST_SUM_WAIT: begin
        cmd.mean_ld = !pipe_busy;
        cmd.acc_clr = !pipe_busy;
      end
      ST_SQ_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sq = 1'b1;
      end
      ST_SQ_WAIT: begin
        cmd.sqrt_load = !pipe_busy;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign addr = (state == ST_IDLE) ? fill : cnt[AW-1:0];
  assign busy = (state != ST_IDLE);

endmodule

### hw/rtl/bmsd_datapath.sv
// Datapath with the sample memory, accumulator, reciprocal mean multiplier and serial square root.
module bmsd_datapath #(
  parameter int GROUP_SIZE = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bmsd_pkg::bmsd_cmd_t                cmd,
  input  logic [$clog2(GROUP_SIZE)-1:0]      addr,
  input  logic [bmsd_pkg::SAMPLE_W-1:0]      sample,
  output logic                               pipe_busy,
  output logic                               done,
  output logic [bmsd_pkg::GROUP_W-1:0]       group_number,
  output logic [bmsd_pkg::SAMPLE_W-1:0]      mean_value,
  output logic [bmsd_pkg::ROOT_W-1:0]        std_dev
);

  localparam int SW     = bmsd_pkg::SAMPLE_W;
  localparam int RTW    = bmsd_pkg::ROOT_W;
  localparam int LW     = $clog2(GROUP_SIZE);
  localparam int SUM_W  = SW + LW;
  localparam int ACC_W  = 2 * SW + LW;
  localparam int SHIFT  = SUM_W + LW;
  localparam int RCP_W  = SUM_W + 2;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam longint RCP =
    ((longint'(1) << SHIFT) + longint'(GROUP_SIZE) - 1) / longint'(GROUP_SIZE);
  localparam logic [RCP_W-1:0] RCP_V   = RCP_W'(RCP);
  localparam logic [ACC_W-1:0] SB_INIT = ACC_W'(GROUP_SIZE) << (2 * RTW - 2);

  logic [SW-1:0]     mem [GROUP_SIZE];
  logic [SW-1:0]     rd_data;
  logic              rd_vld;
  logic              rd_sq;
  logic [SW-1:0]     diff;
  logic              d_vld;
  logic [2*SW-1:0]   sq;
  logic              sq_vld;
  logic [ACC_W-1:0]  acc;
  logic [SW-1:0]     mean;
  logic [PROD_W-1:0] mean_prod;
  logic [RTW-1:0]    root;
  logic [ACC_W-1:0]  nr2;
  logic [ACC_W-1:0]  sp;
  logic [ACC_W-1:0]  sb;
  logic [ACC_W-1:0]  trial;
  logic              s_ge;
  logic [bmsd_pkg::GROUP_W-1:0] group_cnt;

  // The mean is the sum times a rounded-up reciprocal of the group size, shifted down.
  assign mean_prod = PROD_W'(acc[SUM_W-1:0]) * PROD_W'(RCP_V);

  // The root grows one bit per step, MSB first; the trial compares N times its square
  // with the sum of squares, which gives the floor root of the floor variance.
  assign trial = nr2 + sp + sb;
  assign s_ge  = (trial <= acc);

  assign pipe_busy = rd_vld || d_vld || sq_vld;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[addr] <= sample;
    if (cmd.rd_en) rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      rd_sq     <= 1'b0;
      d_vld     <= 1'b0;
      sq_vld    <= 1'b0;
      done      <= 1'b0;
      group_cnt <= '0;
    end else begin
      rd_vld <= cmd.rd_en;
      rd_sq  <= cmd.rd_sq;
      d_vld  <= rd_vld && rd_sq;
      sq_vld <= d_vld;
      done   <= cmd.emit;
      if (cmd.emit) group_cnt <= group_cnt + bmsd_pkg::GROUP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    diff <= (rd_data >= mean) ? (rd_data - mean) : (mean - rd_data);
    sq   <= (2*SW)'(diff) * (2*SW)'(diff);

    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (sq_vld) begin
      acc <= acc + ACC_W'(sq);
    end else if (rd_vld && !rd_sq) begin
      acc <= acc + ACC_W'(rd_data);
    end

    if (cmd.mean_ld) mean <= mean_prod[SHIFT +: SW];

    if (cmd.sqrt_load) begin
      root <= '0;
      nr2  <= '0;
      sp   <= '0;
      sb   <= SB_INIT;
    end else if (cmd.sqrt_step) begin
      root <= {root[RTW-2:0], s_ge};
      nr2  <= s_ge ? trial : nr2;
      sp   <= s_ge ? (sp >> 1) + sb : (sp >> 1);
      sb   <= sb >> 2;
    end

    if (cmd.emit) begin
      group_number <= group_cnt;
      mean_value   <= mean;
      std_dev      <= root;
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Testbench for the block mean and standard deviation unit: sample groups checked against a local predictor.
module tb;

  localparam int N        = 12;
  localparam int SAMPLE_W = bmsd_pkg::SAMPLE_W;
  localparam int GROUP_W  = bmsd_pkg::GROUP_W;
  localparam int ROOT_W   = bmsd_pkg::ROOT_W;

  typedef enum int {SPREAD_FULL, SPREAD_TIGHT, SPREAD_RAILS, SPREAD_FLAT, SPREAD_LOW} spread_t;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    int                  gap;
  } sample_item_t;

  typedef struct {
    logic [GROUP_W-1:0]  group;
    logic [SAMPLE_W-1:0] mean;
    logic [ROOT_W-1:0]   sd;
  } group_stats_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                busy;
  logic                done;
  logic [GROUP_W-1:0]  group_number;
  logic [SAMPLE_W-1:0] mean_value;
  logic [ROOT_W-1:0]   std_dev;

  logic [SAMPLE_W-1:0] group_samples [N];
  int                  fill_n = 0;
  logic [GROUP_W-1:0]  next_group = '0;
  group_stats_t        stats_q [$];
  sample_item_t        pending_q [$];
  sample_item_t        cur_item;
  group_stats_t        want;
  int                  gap_left = 0;
  int                  accepted_n = 0;
  int                  total_n = 0;
  int                  errors = 0;

  block_mean_and_std_dev_unit #(
    .GROUP_SIZE(N)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sample(sample),
    .done(done),
    .group_number(group_number),
    .mean_value(mean_value),
    .std_dev(std_dev)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ROOT_W-1:0] floor_sqrt(logic [63:0] v);
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] trial;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (ROOT_W'(1) << b);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  // Store one accepted item and, when it closes a group, queue the group statistics.
  task automatic take_sample(input logic [SAMPLE_W-1:0] s);
    logic [63:0]  total;
    logic [63:0]  sq_sum;
    logic [63:0]  mean;
    logic [63:0]  d;
    group_stats_t r;
    group_samples[fill_n] = s;
    fill_n++;
    if (fill_n == N) begin
      total = '0;
      for (int i = 0; i < N; i++) total += group_samples[i];
      mean = total / N;
      sq_sum = '0;
      for (int i = 0; i < N; i++) begin
        d = (group_samples[i] >= mean) ? group_samples[i] - mean : mean - group_samples[i];
        sq_sum += d * d;
      end
      r.group = next_group;
      r.mean = mean[SAMPLE_W-1:0];
      r.sd = floor_sqrt(sq_sum / N);
      stats_q.push_back(r);
      next_group++;
      fill_n = 0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(21, 150);
  endfunction

  function automatic logic [SAMPLE_W-1:0] gen_sample(spread_t mode, int base);
    case (mode)
      SPREAD_TIGHT: return SAMPLE_W'(base + $urandom_range(0, 31));
      SPREAD_RAILS: return $urandom_range(0, 1) ? '1 : '0;
      SPREAD_FLAT:  return SAMPLE_W'(base);
      SPREAD_LOW:   return SAMPLE_W'($urandom_range(0, 255));
      default:      return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_group(spread_t mode, int base, bit burst);
    for (int i = 0; i < N; i++)
      pending_q.push_back('{gen_sample(mode, base), burst ? 0 : pick_gap()});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!(start && busy)) begin
      if (start) begin
        take_sample(sample);
        accepted_n++;
      end
      if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0) begin
        cur_item = pending_q.pop_front();
        start <= 1'b1;
        sample <= cur_item.value;
        gap_left <= cur_item.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (stats_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, group_number %0d mean_value %0d std_dev %0d",
                 $time, group_number, mean_value, std_dev);
      end else begin
        want = stats_q.pop_front();
        if (group_number !== want.group) begin
          errors++;
          $display("%0t: group_number expected %0d actual %0d", $time, want.group, group_number);
        end
        if (mean_value !== want.mean) begin
          errors++;
          $display("%0t: mean_value expected %0d actual %0d", $time, want.mean, mean_value);
        end
        if (std_dev !== want.sd) begin
          errors++;
          $display("%0t: std_dev expected %0d actual %0d", $time, want.sd, std_dev);
        end
      end
    end
  end

  initial begin
    // Half the samples at zero and half at full scale give the widest spread.
    for (int i = 0; i < N; i++) pending_q.push_back('{(i % 2) ? '1 : '0, pick_gap()});
    add_group(SPREAD_FLAT, 65535, 1'b0);
    for (int g = 0; g < 35; g++)
      add_group(spread_t'($urandom_range(0, 4)), $urandom_range(0, 65535 - 31),
                $urandom_range(0, 3) == 0);
    // A back-to-back group of zeros closes the run.
    add_group(SPREAD_FLAT, 0, 1'b1);
    total_n = pending_q.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (accepted_n != total_n) @(posedge clk);
    while (stats_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/bmsd_pkg.sv
hw/rtl/bmsd_ctrl.sv
hw/rtl/bmsd_datapath.sv
hw/rtl/block_mean_and_std_dev_unit.sv
dv/tb.sv
